[design/handshake_stall_monitor_defines.svh]
// Assertion helpers used by the monitor's statistics module.
`ifndef HANDSHAKE_STALL_MONITOR_DEFINES_SVH
`define HANDSHAKE_STALL_MONITOR_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define HSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define HSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/hsm_pkg.sv]
`default_nettype none

package hsm_pkg;

  localparam int unsigned CFG_ADDR_WIDTH = 3;
  localparam int unsigned CFG_DATA_WIDTH = 32;
  localparam int unsigned WAIT_WIDTH     = 32;
  localparam logic [WAIT_WIDTH-1:0] WAIT_LIMIT_RESET = 32'd100;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    SIG_FALSE   = 2'd0,
    SIG_TRUE    = 2'd1,
    SIG_UNKNOWN = 2'd2
  } sig_e;

  typedef enum logic {
    REG_WAIT_LIMIT = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic step;
    logic flush;
    logic valid_true;
    logic valid_false;
    logic ready_true;
    logic ready_false;
  } hsm_ctl_t;

endpackage

`default_nettype wire

[design/hsm_in_if.sv]
`default_nettype none

interface hsm_in_if #(
  parameter int unsigned TIME_WIDTH = 63
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [1:0]            valid_state;
  logic [1:0]            ready_state;
  logic [TIME_WIDTH-1:0] stamp;

  modport source (output valid, cmd, valid_state, ready_state, stamp, input ready);
  modport sink   (input valid, cmd, valid_state, ready_state, stamp, output ready);
endinterface

`default_nettype wire

[design/hsm_out_if.sv]
`default_nettype none

interface hsm_out_if #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 63
);
  logic                   valid;
  logic                   ready;
  logic                   finding_valid;
  logic                   finding_open;
  logic [TIME_WIDTH-1:0]  finding_begin_time;
  logic [TIME_WIDTH-1:0]  finding_end_time;
  logic [COUNT_WIDTH-1:0] finding_cycles;
  logic [COUNT_WIDTH-1:0] xfer_count;
  logic [COUNT_WIDTH-1:0] longest_stall_len;
  logic [COUNT_WIDTH-1:0] ready_only_count;
  logic [COUNT_WIDTH-1:0] findings_total;
  logic [COUNT_WIDTH-1:0] samples_total;
  logic [TIME_WIDTH-1:0]  first_active_stamp;
  logic                   has_activity;

  modport source (
    output valid, finding_valid, finding_open, finding_begin_time, finding_end_time,
           finding_cycles, xfer_count, longest_stall_len, ready_only_count,
           findings_total, samples_total, first_active_stamp, has_activity,
    input  ready
  );
  modport sink (
    input  valid, finding_valid, finding_open, finding_begin_time, finding_end_time,
           finding_cycles, xfer_count, longest_stall_len, ready_only_count,
           findings_total, samples_total, first_active_stamp, has_activity,
    output ready
  );
endinterface

`default_nettype wire

[design/hsm_apb_regs.sv]
`default_nettype none

module hsm_apb_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel_i,
  input  wire logic                               penable_i,
  input  wire logic                               pwrite_i,
  input  wire logic [hsm_pkg::CFG_ADDR_WIDTH-1:0] paddr_i,
  input  wire logic [hsm_pkg::CFG_DATA_WIDTH-1:0] pwdata_i,
  output logic      [hsm_pkg::CFG_DATA_WIDTH-1:0] prdata_o,
  output logic                                    pready_o,
  output logic      [hsm_pkg::WAIT_WIDTH-1:0]     wait_limit_o
);
  import hsm_pkg::*;

  logic [WAIT_WIDTH-1:0] limit_q, limit_d;
  reg_idx_e              reg_idx;
  logic                  wr_en;

  assign reg_idx  = reg_idx_e'(paddr_i[CFG_ADDR_WIDTH-1:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_comb begin
    limit_d  = limit_q;
    prdata_o = '0;
    unique case (reg_idx)
      REG_WAIT_LIMIT: begin
        prdata_o = CFG_DATA_WIDTH'(limit_q);
        if (wr_en) begin
          limit_d = pwdata_i[WAIT_WIDTH-1:0];
        end
      end
      default: begin
        prdata_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= WAIT_LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign wait_limit_o = limit_q;

endmodule

`default_nettype wire

[design/hsm_stats.sv]
`default_nettype none
`include "handshake_stall_monitor_defines.svh"

module hsm_stats #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 63
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hsm_pkg::hsm_ctl_t              ctl_i,
  input  wire logic [TIME_WIDTH-1:0]          time_i,
  input  wire logic [hsm_pkg::WAIT_WIDTH-1:0] max_wait_i,
  output logic                                finding_valid_o,
  output logic                                finding_open_o,
  output logic      [TIME_WIDTH-1:0]          finding_begin_time_o,
  output logic      [TIME_WIDTH-1:0]          finding_end_time_o,
  output logic      [COUNT_WIDTH-1:0]         finding_cycles_o,
  output logic      [COUNT_WIDTH-1:0]         transfer_count_o,
  output logic      [COUNT_WIDTH-1:0]         max_stall_cycles_o,
  output logic      [COUNT_WIDTH-1:0]         ready_only_count_o,
  output logic      [COUNT_WIDTH-1:0]         finding_count_o,
  output logic      [COUNT_WIDTH-1:0]         sample_count_o,
  output logic      [TIME_WIDTH-1:0]          first_activity_time_o,
  output logic                                has_activity_o
);
  import hsm_pkg::*;

  localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > WAIT_WIDTH) ? COUNT_WIDTH : WAIT_WIDTH;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  logic [COUNT_WIDTH-1:0] stall_len_q, stall_len_d;
  logic [TIME_WIDTH-1:0]  start_q, start_d;
  logic [COUNT_WIDTH-1:0] longest_q, longest_d;
  logic [COUNT_WIDTH-1:0] transfers_q, transfers_d;
  logic [COUNT_WIDTH-1:0] ronly_q, ronly_d;
  logic [COUNT_WIDTH-1:0] findings_q, findings_d;
  logic [COUNT_WIDTH-1:0] samples_q, samples_d;
  logic                   act_q, act_d;
  logic [TIME_WIDTH-1:0]  act_time_q, act_time_d;

  logic sample, xfer, stall, ronly, closing, close_nz, found;

  assign sample   = ctl_i.step && !ctl_i.flush;
  assign xfer     = ctl_i.valid_true && ctl_i.ready_true;
  assign stall    = ctl_i.valid_true && ctl_i.ready_false;
  assign ronly    = ctl_i.ready_true && ctl_i.valid_false;
  assign closing  = ctl_i.step && (ctl_i.flush || xfer);
  assign close_nz = (stall_len_q != '0);
  assign found    = closing && close_nz
                    && (CMP_WIDTH'(stall_len_q) > CMP_WIDTH'(max_wait_i));

  always_comb begin
    stall_len_d = stall_len_q;
    start_d     = start_q;
    longest_d   = longest_q;
    transfers_d = transfers_q;
    ronly_d     = ronly_q;
    findings_d  = findings_q;
    samples_d   = samples_q;
    act_d       = act_q;
    act_time_d  = act_time_q;

    if (closing && close_nz && (stall_len_q > longest_q)) begin
      longest_d = stall_len_q;
    end
    if (found) begin
      findings_d = sat_inc(findings_q);
    end
    if (sample) begin
      samples_d = sat_inc(samples_q);
      if (!act_q && (ctl_i.valid_true || ctl_i.ready_true)) begin
        act_d      = 1'b1;
        act_time_d = time_i;
      end
      if (xfer) begin
        transfers_d = sat_inc(transfers_q);
        stall_len_d = '0;
      end else if (stall) begin
        if (!close_nz) begin
          start_d = time_i;
        end
        stall_len_d = sat_inc(stall_len_q);
      end else if (ronly) begin
        ronly_d = sat_inc(ronly_q);
      end
    end
  end

  assign finding_valid_o       = found;
  assign finding_open_o        = found && ctl_i.flush;
  assign finding_begin_time_o  = found ? start_q : '0;
  assign finding_end_time_o    = found ? time_i : '0;
  assign finding_cycles_o      = found ? stall_len_q : '0;
  assign transfer_count_o      = transfers_d;
  assign max_stall_cycles_o    = longest_d;
  assign ready_only_count_o    = ronly_d;
  assign finding_count_o       = findings_d;
  assign sample_count_o        = samples_d;
  assign first_activity_time_o = act_d ? act_time_d : '0;
  assign has_activity_o        = act_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_len_q <= '0;
      start_q     <= '0;
      longest_q   <= '0;
      transfers_q <= '0;
      ronly_q     <= '0;
      findings_q  <= '0;
      samples_q   <= '0;
      act_q       <= 1'b0;
      act_time_q  <= '0;
    end else if (ctl_i.step && ctl_i.flush) begin
      stall_len_q <= '0;
      start_q     <= '0;
      longest_q   <= '0;
      transfers_q <= '0;
      ronly_q     <= '0;
      findings_q  <= '0;
      samples_q   <= '0;
      act_q       <= 1'b0;
      act_time_q  <= '0;
    end else begin
      stall_len_q <= stall_len_d;
      start_q     <= start_d;
      longest_q   <= longest_d;
      transfers_q <= transfers_d;
      ronly_q     <= ronly_d;
      findings_q  <= findings_d;
      samples_q   <= samples_d;
      act_q       <= act_d;
      act_time_q  <= act_time_d;
    end
  end

  `HSM_ASSERT_NEXT(a_flush_clears, clk_i, rst_ni, ctl_i.step && ctl_i.flush, samples_q == '0 && stall_len_q == '0 && !act_q, "window state not cleared after flush")
  `HSM_ASSERT_NEXT(a_findings_hold, clk_i, rst_ni, !(ctl_i.step && (ctl_i.flush || found)), findings_q == $past(findings_q), "finding count moved without a finding")
  `HSM_ASSERT_NEXT(a_stall_start_hold, clk_i, rst_ni, sample && close_nz && !xfer, start_q == $past(start_q), "stall start time moved during an open stall")

endmodule

`default_nettype wire

[design/handshake_stall_monitor.sv]
// Pipeline: an input register captures each accepted transaction, and the
//   result registers load from it through the statistics logic.
// Throughput: one transaction per cycle through combinational logic between the
//   input and result registers; input stalls only while both stages are full
//   and the sink holds off.
// Reset: asynchronous, active low; clears the window state and both stage valid
//   flags, and sets the wait limit to 100.
`default_nettype none

module handshake_stall_monitor #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 63
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  hsm_in_if.sink                                  in_i,
  hsm_out_if.source                               out_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [hsm_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  wire logic [hsm_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output logic      [hsm_pkg::CFG_DATA_WIDTH-1:0] prdata,
  output logic                                    pready
);
  import hsm_pkg::*;

  logic [WAIT_WIDTH-1:0] wait_limit;

  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_cmd_q;
  logic [1:0]            s1_vstate_q;
  logic [1:0]            s1_rstate_q;
  logic [TIME_WIDTH-1:0] s1_time_q;

  logic out_free, in_take, step;
  hsm_ctl_t ctl;

  logic                   r_finding_valid, r_finding_open, r_has_activity;
  logic [TIME_WIDTH-1:0]  r_begin_time, r_end_time, r_first_time;
  logic [COUNT_WIDTH-1:0] r_cycles, r_transfers, r_max_stall, r_ronly, r_findings, r_samples;

  logic                   out_valid_q, out_valid_d;
  logic                   fv_q, fo_q, act_q;
  logic [TIME_WIDTH-1:0]  begin_q, end_q, first_q;
  logic [COUNT_WIDTH-1:0] cycles_q, transfers_q, max_stall_q, ronly_q, findings_q, samples_q;

  hsm_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_o     (prdata),
    .pready_o     (pready),
    .wait_limit_o (wait_limit)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q    <= in_i.cmd;
      s1_vstate_q <= in_i.valid_state;
      s1_rstate_q <= in_i.ready_state;
      s1_time_q   <= in_i.stamp;
    end
  end

  // decode the sampled levels; unknown and the spare code match neither side
  assign ctl.step        = step;
  assign ctl.flush       = (s1_cmd_q == CMD_FLUSH);
  assign ctl.valid_true  = (s1_vstate_q == SIG_TRUE);
  assign ctl.valid_false = (s1_vstate_q == SIG_FALSE);
  assign ctl.ready_true  = (s1_rstate_q == SIG_TRUE);
  assign ctl.ready_false = (s1_rstate_q == SIG_FALSE);

  hsm_stats #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_stats (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .ctl_i                 (ctl),
    .time_i                (s1_time_q),
    .max_wait_i            (wait_limit),
    .finding_valid_o       (r_finding_valid),
    .finding_open_o        (r_finding_open),
    .finding_begin_time_o  (r_begin_time),
    .finding_end_time_o    (r_end_time),
    .finding_cycles_o      (r_cycles),
    .transfer_count_o      (r_transfers),
    .max_stall_cycles_o    (r_max_stall),
    .ready_only_count_o    (r_ronly),
    .finding_count_o       (r_findings),
    .sample_count_o        (r_samples),
    .first_activity_time_o (r_first_time),
    .has_activity_o        (r_has_activity)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      fv_q        <= r_finding_valid;
      fo_q        <= r_finding_open;
      begin_q     <= r_begin_time;
      end_q       <= r_end_time;
      cycles_q    <= r_cycles;
      transfers_q <= r_transfers;
      max_stall_q <= r_max_stall;
      ronly_q     <= r_ronly;
      findings_q  <= r_findings;
      samples_q   <= r_samples;
      first_q     <= r_first_time;
      act_q       <= r_has_activity;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.finding_valid      = fv_q;
  assign out_o.finding_open       = fo_q;
  assign out_o.finding_begin_time = begin_q;
  assign out_o.finding_end_time   = end_q;
  assign out_o.finding_cycles     = cycles_q;
  assign out_o.xfer_count         = transfers_q;
  assign out_o.longest_stall_len  = max_stall_q;
  assign out_o.ready_only_count   = ronly_q;
  assign out_o.findings_total     = findings_q;
  assign out_o.samples_total      = samples_q;
  assign out_o.first_active_stamp = first_q;
  assign out_o.has_activity       = act_q;

endmodule

`default_nettype wire

[test/tb_handshake_stall_monitor.sv]
`timescale 1ns / 100ps

module tb_handshake_stall_monitor;
  import hsm_pkg::*;

  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned TIME_W      = 63;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 72;

  typedef struct packed {
    cmd_e              cmd;
    logic [1:0]        valid_state;
    logic [1:0]        ready_state;
    logic [TIME_W-1:0] stamp;
  } probe_item_t;

  typedef struct packed {
    logic               finding_valid;
    logic               finding_open;
    logic [TIME_W-1:0]  finding_begin_time;
    logic [TIME_W-1:0]  finding_end_time;
    logic [COUNT_W-1:0] finding_cycles;
    logic [COUNT_W-1:0] xfer_count;
    logic [COUNT_W-1:0] longest_stall_len;
    logic [COUNT_W-1:0] ready_only_count;
    logic [COUNT_W-1:0] findings_total;
    logic [COUNT_W-1:0] samples_total;
    logic [TIME_W-1:0]  first_active_stamp;
    logic               has_activity;
  } stall_report_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_ADDR_WIDTH-1:0] paddr;
  logic [CFG_DATA_WIDTH-1:0] pwdata;
  logic [CFG_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  hsm_in_if #(.TIME_WIDTH(TIME_W)) in_if ();
  hsm_out_if #(.COUNT_WIDTH(COUNT_W), .TIME_WIDTH(TIME_W)) out_if ();

  handshake_stall_monitor #(
    .COUNT_WIDTH(COUNT_W),
    .TIME_WIDTH (TIME_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor state
  logic [WAIT_WIDTH-1:0] wait_limit;
  logic [COUNT_W-1:0]    stall_len;
  logic [TIME_W-1:0]     stall_from;
  logic [COUNT_W-1:0]    longest;
  logic [COUNT_W-1:0]    transfers_n;
  logic [COUNT_W-1:0]    ready_only_n;
  logic [COUNT_W-1:0]    findings_n;
  logic [COUNT_W-1:0]    samples_n;
  logic                  act_seen;
  logic [TIME_W-1:0]     act_time;

  probe_item_t   probe_q[$];
  stall_report_t report_q[$];

  probe_item_t   cur_probe;
  logic          offering;
  int unsigned   src_gap;
  int unsigned   src_burst;
  logic          sink_open;
  int unsigned   sink_gap;
  int unsigned   sink_burst;
  int unsigned   sink_hold;
  int unsigned   results_seen;
  int unsigned   next_hold_at;
  int unsigned   mismatches;
  int unsigned   cycle_count;
  logic [TIME_W-1:0] clock_now;

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_window_state();
    stall_len    = '0;
    stall_from   = '0;
    longest      = '0;
    transfers_n  = '0;
    ready_only_n = '0;
    findings_n   = '0;
    samples_n    = '0;
    act_seen     = 1'b0;
    act_time     = '0;
  endfunction

  function automatic logic close_stall_run();
    if (stall_len == '0) return 1'b0;
    if (stall_len > longest) longest = stall_len;
    if (stall_len > wait_limit) begin
      findings_n = sat_inc(findings_n);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic stall_report_t track_item(probe_item_t it);
    stall_report_t res;
    logic v_true, v_false, r_true, r_false, found;
    res     = '0;
    found   = 1'b0;
    v_true  = (it.valid_state == SIG_TRUE);
    v_false = (it.valid_state == SIG_FALSE);
    r_true  = (it.ready_state == SIG_TRUE);
    r_false = (it.ready_state == SIG_FALSE);
    if (it.cmd == CMD_SAMPLE) begin
      samples_n = sat_inc(samples_n);
      if (!act_seen && (v_true || r_true)) begin
        act_seen = 1'b1;
        act_time = it.stamp;
      end
      if (v_true && r_true) begin
        transfers_n = sat_inc(transfers_n);
        res.finding_begin_time = stall_from;
        res.finding_cycles     = stall_len;
        found = close_stall_run();
        stall_len = '0;
      end else if (v_true && r_false) begin
        if (stall_len == '0) stall_from = it.stamp;
        stall_len = sat_inc(stall_len);
      end else if (r_true && v_false) begin
        ready_only_n = sat_inc(ready_only_n);
      end
    end else begin
      res.finding_begin_time = stall_from;
      res.finding_cycles     = stall_len;
      found = close_stall_run();
      res.finding_open = found;
    end
    res.finding_end_time = it.stamp;
    if (!found) begin
      res.finding_begin_time = '0;
      res.finding_end_time   = '0;
      res.finding_cycles     = '0;
    end
    res.finding_valid      = found;
    res.xfer_count         = transfers_n;
    res.longest_stall_len  = longest;
    res.ready_only_count   = ready_only_n;
    res.findings_total     = findings_n;
    res.samples_total      = samples_n;
    res.first_active_stamp = act_seen ? act_time : '0;
    res.has_activity       = act_seen;
    if (it.cmd == CMD_FLUSH) clear_window_state();
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      mismatches++;
    end
  endfunction

  function automatic void compare_report(stall_report_t exp);
    check_field("finding_valid", exp.finding_valid, out_if.finding_valid);
    check_field("finding_open", exp.finding_open, out_if.finding_open);
    check_field("finding_begin_time", exp.finding_begin_time, out_if.finding_begin_time);
    check_field("finding_end_time", exp.finding_end_time, out_if.finding_end_time);
    check_field("finding_cycles", exp.finding_cycles, out_if.finding_cycles);
    check_field("xfer_count", exp.xfer_count, out_if.xfer_count);
    check_field("longest_stall_len", exp.longest_stall_len, out_if.longest_stall_len);
    check_field("ready_only_count", exp.ready_only_count, out_if.ready_only_count);
    check_field("findings_total", exp.findings_total, out_if.findings_total);
    check_field("samples_total", exp.samples_total, out_if.samples_total);
    check_field("first_active_stamp", exp.first_active_stamp, out_if.first_active_stamp);
    check_field("has_activity", exp.has_activity, out_if.has_activity);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TIME_W-1:0] random_stamp();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp();
    if ($urandom_range(0, 9) == 0) return random_stamp();
    clock_now = clock_now + TIME_W'($urandom_range(1, 20));
    return clock_now;
  endfunction

  function automatic void push_probe(cmd_e c, logic [1:0] v, logic [1:0] r,
                                     logic [TIME_W-1:0] t);
    probe_item_t it;
    it.cmd         = c;
    it.valid_state = v;
    it.ready_state = r;
    it.stamp       = t;
    probe_q.insert(probe_q.size(), it);
  endfunction

  // Anything that neither transfers nor stalls
  function automatic void push_noise();
    logic [1:0] v, r;
    do begin
      v = 2'($urandom_range(0, 3));
      r = 2'($urandom_range(0, 3));
    end while (v == SIG_TRUE && (r == SIG_TRUE || r == SIG_FALSE));
    push_probe(CMD_SAMPLE, v, r, next_stamp());
  endfunction

  function automatic void queue_random_phase(int unsigned budget);
    int unsigned made, kind, len, k;
    made = 0;
    while (made < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        if (wait_limit < 16) begin
          len = wait_limit + $urandom_range(0, 3);
          len = (len > 1) ? len - 1 : 1;
        end else begin
          len = $urandom_range(1, 8);
        end
        for (k = 0; k < len; k++) begin
          push_probe(CMD_SAMPLE, SIG_TRUE, SIG_FALSE, next_stamp());
          made++;
          if ($urandom_range(0, 4) == 0) begin
            push_noise();
            made++;
          end
        end
        if ($urandom_range(0, 4) == 0) push_probe(CMD_FLUSH, 2'($urandom_range(0, 3)),
                                                  2'($urandom_range(0, 3)), next_stamp());
        else push_probe(CMD_SAMPLE, SIG_TRUE, SIG_TRUE, next_stamp());
        made++;
      end else if (kind < 70) begin
        push_probe(CMD_SAMPLE, SIG_TRUE, SIG_TRUE, next_stamp());
        made++;
      end else if (kind < 92) begin
        push_probe(($urandom_range(0, 15) == 0) ? CMD_FLUSH : CMD_SAMPLE,
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), random_stamp());
        made++;
      end else begin
        push_probe(CMD_FLUSH, SIG_FALSE, SIG_FALSE, next_stamp());
        made++;
      end
    end
  endfunction

  task automatic wait_idle();
    while (probe_q.size() != 0 || offering || report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_wait_limit(logic [WAIT_WIDTH-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_WIDTH'(4 * REG_WAIT_LIMIT);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    wait_limit = value;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      offering = 1'b0;
      src_gap  = 0;
      in_if.valid <= 1'b0;
    end else begin
      if (offering && in_if.ready) begin
        report_q.insert(report_q.size(), track_item(cur_probe));
        offering = 1'b0;
      end
      if (!offering) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (probe_q.size() > 0) begin
          cur_probe = probe_q.pop_front();
          offering  = 1'b1;
          in_if.cmd         <= cur_probe.cmd;
          in_if.valid_state <= cur_probe.valid_state;
          in_if.ready_state <= cur_probe.ready_state;
          in_if.stamp       <= cur_probe.stamp;
          if (src_burst > 0) begin
            src_burst--;
            src_gap = 0;
          end else begin
            src_gap = pick_gap();
            if ($urandom_range(0, 19) == 0) src_burst = $urandom_range(10, 30);
          end
        end
      end
      in_if.valid <= offering;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (report_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          mismatches++;
        end else begin
          compare_report(report_q.pop_front());
        end
      end
      if (sink_hold == 0 && results_seen >= next_hold_at && probe_q.size() > 20) begin
        sink_hold    = 80;
        next_hold_at = next_hold_at + 200;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        sink_open = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        sink_open = 1'b0;
      end else if (sink_burst > 0) begin
        sink_burst--;
        sink_open = 1'b1;
      end else begin
        sink_gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if ($urandom_range(0, 29) == 0) sink_burst = $urandom_range(10, 40);
        sink_open = (sink_gap == 0);
        if (sink_gap > 0) sink_gap--;
      end
      out_if.ready <= sink_open;
    end
  end

  initial begin
    logic [WAIT_WIDTH-1:0] limits[6];
    int unsigned p;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_SAMPLE;
    in_if.valid_state = SIG_FALSE;
    in_if.ready_state = SIG_FALSE;
    in_if.stamp       = '0;
    out_if.ready      = 1'b0;
    offering     = 1'b0;
    src_gap      = 0;
    src_burst    = 0;
    sink_gap     = 0;
    sink_burst   = 0;
    sink_hold    = 0;
    results_seen = 0;
    next_hold_at = 60;
    mismatches   = 0;
    cycle_count  = 0;
    clock_now    = '0;
    wait_limit   = WAIT_LIMIT_RESET;
    clear_window_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limit: unknown and invalid encodings, activity, short stalls, flushes
    push_probe(CMD_SAMPLE, SIG_FALSE, SIG_FALSE, '0);
    push_probe(CMD_SAMPLE, SIG_UNKNOWN, SIG_UNKNOWN, 63'd5);
    push_probe(CMD_SAMPLE, 2'd3, SIG_TRUE, 63'd7);
    push_probe(CMD_SAMPLE, SIG_FALSE, SIG_TRUE, 63'd9);
    push_probe(CMD_SAMPLE, SIG_TRUE, 2'd3, 63'd11);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_TRUE, 63'd13);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_FALSE, 63'd15);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_FALSE, 63'd17);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_TRUE, '1);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_FALSE, 63'd20);
    push_probe(CMD_FLUSH, SIG_FALSE, SIG_FALSE, '1);
    push_probe(CMD_FLUSH, SIG_TRUE, SIG_TRUE, '0);
    wait_idle();

    // Zero limit: every stall is long
    write_wait_limit('0);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_FALSE, '1);
    push_probe(CMD_SAMPLE, SIG_FALSE, SIG_FALSE, 63'd2);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_TRUE, '0);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_FALSE, 63'd100);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_UNKNOWN, 63'd101);
    push_probe(CMD_SAMPLE, SIG_TRUE, SIG_FALSE, 63'd102);
    push_probe(CMD_FLUSH, SIG_FALSE, SIG_FALSE, '1);
    push_probe(CMD_FLUSH, SIG_FALSE, SIG_FALSE, 63'd3);
    push_probe(CMD_SAMPLE, 2'd3, 2'd3, '1);
    wait_idle();

    limits[0] = '1;
    limits[1] = 32'd3;
    limits[2] = '0;
    limits[3] = {$urandom};
    limits[4] = WAIT_WIDTH'($urandom_range(1, 12));
    limits[5] = 32'd1;
    for (p = 0; p < 6; p++) begin
      write_wait_limit(limits[p]);
      queue_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/hsm_pkg.sv
design/hsm_in_if.sv
design/hsm_out_if.sv
design/hsm_apb_regs.sv
design/hsm_stats.sv
design/handshake_stall_monitor.sv
test/tb_handshake_stall_monitor.sv
